// ===== hdl/assert_macros.svh =====
// Assertion helpers; clk and arst_n must be in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tbwm_pkg.sv =====
package tbwm_pkg;

	localparam int MEMORY_BYTES_DEF = 65536;
	localparam int ADDR_W           = 16;
	localparam int DATA_W           = 16;
	localparam int FUNC_W           = 3;

	// beat layout, lowest bit first
	localparam int IN_FUNC_LSB  = 0;
	localparam int IN_ADDR_LSB  = IN_FUNC_LSB + FUNC_W;
	localparam int IN_WDATA_LSB = IN_ADDR_LSB + ADDR_W;
	localparam int IN_BITS      = IN_WDATA_LSB + DATA_W;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = DATA_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_RD_BYTE = 3'd0,
		FN_RD_WORD = 3'd1,
		FN_WR_BYTE = 3'd2,
		FN_WR_WORD = 3'd3,
		FN_GET_FLG = 3'd4,
		FN_CLR_FLG = 3'd5
	} func_t;

	localparam logic [1:0] FLAG_RD = 2'b01;
	localparam logic [1:0] FLAG_WR = 2'b10;

	typedef struct packed {
		logic [1:0] flags;
		logic [7:0] data;
	} entry_t;

	typedef logic [7:0] calib_t [8];
	localparam calib_t CALIB = '{8'h95, 8'h8F, 8'h9E, 8'h8E, 8'h92, 8'h8D, 8'hD1, 8'h86};

	// power-up contents of one byte
	function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
		logic [7:0] v;
		if (a[15:8] == 8'h10) begin
			if (a[7:3] == 5'h1F)
				v = CALIB[a[2:0]];
			else
				v = 8'hFF;
		end else if (a[15:14] == 2'b11) begin
			v = 8'hFF;
		end else begin
			v = 8'h00;
		end
		return v;
	endfunction

endpackage

// ===== hdl/tbwm_bank.sv =====
module tbwm_bank #(
	parameter int ROWS = tbwm_pkg::MEMORY_BYTES_DEF / 2,
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic                clk,
	input  logic                en,
	input  logic                we,
	input  logic [ROW_W-1:0]    row,
	input  tbwm_pkg::entry_t    wdata,
	output tbwm_pkg::entry_t    rdata
);

	tbwm_pkg::entry_t mem [ROWS];
	tbwm_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[row] <= wdata;
			else
				rdata_q <= mem[row];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tbwm_init.sv =====
module tbwm_init #(
	parameter int ROWS = tbwm_pkg::MEMORY_BYTES_DEF / 2,
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             busy,
	output logic [ROW_W-1:0] row
);

	logic             busy_q;
	logic [ROW_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (busy_q) begin
			row_q <= row_q + ROW_W'(1);
			if (row_q == ROW_W'(ROWS - 1))
				busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign row  = row_q;

endmodule

// ===== hdl/tracked_byte_word_memory_core.sv =====
// 64 KiB byte memory with per-byte read/written flags, held as an even and an
// odd bank of single-port RAM (byte plus two flag bits per entry), so a word
// at any address touches one row of each bank. After reset the core sweeps
// both banks, one row per cycle, writing the power-up image (0xFF regions,
// calibration bytes, cleared flags), during which s_tready is low. Afterwards
// the banks are read on the accepting edge and written back in ST_MOD once the
// result register is free; no new beat is taken until that write-back commits.
`include "assert_macros.svh"

module tracked_byte_word_memory_core #(
	parameter int MEMORY_BYTES = tbwm_pkg::MEMORY_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tbwm_pkg::IN_TDATA_W-1:0]     s_tdata,  // func, address, write_data, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tbwm_pkg::OUT_TDATA_W-1:0]    m_tdata   // read_data, cell_flags, zero pad
);

	localparam int ROWS  = MEMORY_BYTES / 2;
	localparam int ROW_W = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_INIT = 3'b001,
		ST_IDLE = 3'b010,
		ST_MOD  = 3'b100
	} state_t;

	state_t state_q;

	logic                            init_busy;
	logic [ROW_W-1:0]                init_row;
	tbwm_pkg::func_t                 func_s1;
	logic [tbwm_pkg::ADDR_W-1:0]     addr_s1;
	logic [tbwm_pkg::DATA_W-1:0]     wdata_s1;
	logic                            m_tvalid_q;
	logic [tbwm_pkg::DATA_W-1:0]     rdata_q;
	logic [1:0]                      flags_q;

	logic                            accept;
	logic                            out_free;
	logic                            commit;
	logic [tbwm_pkg::ADDR_W-1:0]     in_addr;
	logic [ROW_W-1:0]                in_row;
	logic                            en_ev, en_od, we_ev, we_od;
	logic [ROW_W-1:0]                row_ev, row_od;
	tbwm_pkg::entry_t                wr_ev, wr_od, rd_ev, rd_od;
	tbwm_pkg::entry_t                b0, b1, nb0, nb1;
	logic                            w0, w1;
	logic [tbwm_pkg::DATA_W-1:0]     res_data;
	logic [1:0]                      res_flags;

	tbwm_init #(.ROWS(ROWS)) u_init (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (init_busy),
		.row    (init_row)
	);

	tbwm_bank #(.ROWS(ROWS)) u_bank_ev (
		.clk(clk), .en(en_ev), .we(we_ev), .row(row_ev), .wdata(wr_ev), .rdata(rd_ev)
	);

	tbwm_bank #(.ROWS(ROWS)) u_bank_od (
		.clk(clk), .en(en_od), .we(we_od), .row(row_od), .wdata(wr_od), .rdata(rd_od)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == ST_MOD) && out_free;
	assign in_addr  = s_tdata[tbwm_pkg::IN_ADDR_LSB +: tbwm_pkg::ADDR_W];
	assign in_row   = in_addr[ROW_W:1];

	// first and second byte of the access, in address order
	always_comb begin
		b0 = addr_s1[0] ? rd_od : rd_ev;
		b1 = addr_s1[0] ? rd_ev : rd_od;
		nb0 = b0;
		nb1 = b1;
		w0 = 1'b0;
		w1 = 1'b0;
		res_data = '0;
		res_flags = '0;
		case (func_s1)
			tbwm_pkg::FN_RD_BYTE: begin
				nb0.flags = b0.flags | tbwm_pkg::FLAG_RD;
				w0 = 1'b1;
				res_data = {8'h00, b0.data};
			end
			tbwm_pkg::FN_RD_WORD: begin
				nb0.flags = b0.flags | tbwm_pkg::FLAG_RD;
				nb1.flags = b1.flags | tbwm_pkg::FLAG_RD;
				w0 = 1'b1;
				w1 = 1'b1;
				res_data = {b1.data, b0.data};
			end
			tbwm_pkg::FN_WR_BYTE: begin
				nb0.flags = b0.flags | tbwm_pkg::FLAG_WR;
				nb0.data = wdata_s1[7:0];
				w0 = 1'b1;
			end
			tbwm_pkg::FN_WR_WORD: begin
				nb0.flags = b0.flags | tbwm_pkg::FLAG_WR;
				nb1.flags = b1.flags | tbwm_pkg::FLAG_WR;
				nb0.data = wdata_s1[7:0];
				nb1.data = wdata_s1[15:8];
				w0 = 1'b1;
				w1 = 1'b1;
			end
			tbwm_pkg::FN_GET_FLG: begin
				res_flags = b0.flags;
			end
			tbwm_pkg::FN_CLR_FLG: begin
				nb0.flags = 2'b00;
				w0 = 1'b1;
			end
			default: ;
		endcase
	end

	// bank port steering: init sweep, read on accept, write-back on commit
	always_comb begin
		en_ev = 1'b0;
		en_od = 1'b0;
		we_ev = 1'b0;
		we_od = 1'b0;
		row_ev = in_row + ROW_W'(in_addr[0]);  // odd start: high byte in next even row
		row_od = in_row;
		wr_ev = addr_s1[0] ? nb1 : nb0;
		wr_od = addr_s1[0] ? nb0 : nb1;
		if (state_q == ST_INIT) begin
			en_ev = 1'b1;
			en_od = 1'b1;
			we_ev = 1'b1;
			we_od = 1'b1;
			row_ev = init_row;
			row_od = init_row;
			wr_ev = '{flags: 2'b00, data: tbwm_pkg::init_byte({init_row, 1'b0})};
			wr_od = '{flags: 2'b00, data: tbwm_pkg::init_byte({init_row, 1'b1})};
		end else if (accept) begin
			en_ev = 1'b1;
			en_od = 1'b1;
		end else if (commit) begin
			en_ev = addr_s1[0] ? w1 : w0;
			en_od = addr_s1[0] ? w0 : w1;
			we_ev = 1'b1;
			we_od = 1'b1;
			row_ev = addr_s1[ROW_W:1] + ROW_W'(addr_s1[0]);
			row_od = addr_s1[ROW_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: if (!init_busy || init_row == ROW_W'(ROWS - 1)) state_q <= ST_IDLE;
				ST_IDLE: if (accept) state_q <= ST_MOD;
				ST_MOD:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_INIT;
			endcase
			if (commit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= tbwm_pkg::func_t'(s_tdata[tbwm_pkg::IN_FUNC_LSB +: tbwm_pkg::FUNC_W]);
			addr_s1  <= in_addr;
			wdata_s1 <= s_tdata[tbwm_pkg::IN_WDATA_LSB +: tbwm_pkg::DATA_W];
		end
		if (commit) begin
			rdata_q <= res_data;
			flags_q <= res_flags;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(tbwm_pkg::OUT_TDATA_W - tbwm_pkg::OUT_BITS)'(0), flags_q, rdata_q};

	`ASSERT_NXT(a_accept_to_mod, accept, state_q == ST_MOD, "accepted beat did not enter write-back")
	`ASSERT_NXT(a_commit_result, commit, m_tvalid_q, "write-back produced no result")
	`ASSERT_IMP(a_no_access_in_init, state_q == ST_INIT, !accept && !commit,
		"access during initial sweep")
	`ASSERT_IMP(a_result_slot_free, commit && m_tvalid_q, m_tready,
		"result overwritten before it was taken")

endmodule
